/* rtl/core/mll_pkg.sv */
package mll_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STATE_BITS  = 32;
  localparam int COEF_FRAC   = 22;
  localparam int GAIN_BITS   = 23;
  localparam int POLE_BITS   = 24;
  localparam int RES_BITS    = 25;
  localparam int CFG_BITS    = 25;
  localparam int CFG_IDX_BITS = 2;
  localparam int COEF_BITS   = 26;
  localparam int DEN_BITS    = 25;
  localparam int HEADROOM    = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_GAIN     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_POLE     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RESONANCE_GAIN = 2'd2;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << COEF_FRAC;
  localparam logic signed [POLE_BITS-1:0] POLE_ONE = POLE_BITS'(1) << COEF_FRAC;
  localparam logic signed [POLE_BITS-1:0] POLE_MONE = -(POLE_BITS'(1) << COEF_FRAC);
  localparam logic [RES_BITS-1:0] RES_MAX = RES_BITS'(4) << COEF_FRAC;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_B2, OP_B4, OP_O1, OP_O2, OP_O3, OP_NUM, OP_DEN,
    OP_DINIT, OP_DSTEP, OP_QUOT, OP_U, OP_BP, OP_F, OP_N, OP_N4, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_B2, ST_B4, ST_O1, ST_O2, ST_O3, ST_NUM, ST_DEN, ST_DINIT,
    ST_DIV, ST_QUOT, ST_U, ST_BP, ST_F, ST_N, ST_BP4, ST_N4, ST_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
  } cmd_t;

endpackage

/* rtl/core/mll_dp.sv */
module mll_dp #(
  parameter int SampleBits = mll_pkg::SAMPLE_BITS,
  parameter int StateBits  = mll_pkg::STATE_BITS,
  parameter int WorkBits   = mll_pkg::STATE_BITS + mll_pkg::HEADROOM,
  parameter int DivBits    = WorkBits + mll_pkg::COEF_FRAC + 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mll_pkg::cmd_t                         cmd_i,
  input  logic                                  cfg_we_i,
  input  logic [mll_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [mll_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  logic signed [SampleBits-1:0]          sample_in_i,
  input  logic                                  clear_state_i,
  output logic signed [SampleBits-1:0]          sample_out_o
);

  localparam int W    = WorkBits;
  localparam int CW   = mll_pkg::COEF_BITS;
  localparam int PW   = W + CW;
  localparam int FR   = mll_pkg::COEF_FRAC;
  localparam int DW   = mll_pkg::DEN_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FR - 1);
  localparam logic signed [W-1:0] ONE_W = W'(1) << FR;

  logic [mll_pkg::GAIN_BITS-1:0]        gain_q;
  logic signed [mll_pkg::POLE_BITS-1:0] pole_q;
  logic [mll_pkg::RES_BITS-1:0]         res_q;

  logic [mll_pkg::GAIN_BITS-1:0]        b0c;
  logic signed [mll_pkg::POLE_BITS-1:0] a1c;
  logic [mll_pkg::RES_BITS-1:0]         kc;
  logic signed [CW-1:0] b0s, a1s, ks;

  logic signed [StateBits-1:0] st_q [4];
  logic signed [CW-1:0] b2_q, b4_q;
  logic signed [W-1:0]  x_q, t_q, num_q, outs_q, f_q, bp_q;
  logic [DW-1:0]        den_q, rem_q;
  logic [DivBits-1:0]   qr_q;
  logic                 neg_q;
  logic signed [SampleBits-1:0] out_q;

  logic signed [W-1:0]  s_sel, s0w, s1w, s2w, s3w;
  logic signed [W-1:0]  mul_a, mul_r, nv, mag, quo;
  logic signed [CW-1:0] mul_c;
  logic signed [PW-1:0] prod, prod_r;
  logic [DW:0]          cand;
  logic [StateBits-1:0] zap_v;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      pole_q <= mll_pkg::POLE_MONE;
      res_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mll_pkg::REG_STAGE_GAIN:     gain_q <= cfg_data_i[mll_pkg::GAIN_BITS-1:0];
        mll_pkg::REG_STAGE_POLE:     pole_q <= cfg_data_i[mll_pkg::POLE_BITS-1:0];
        mll_pkg::REG_RESONANCE_GAIN: res_q  <= cfg_data_i[mll_pkg::RES_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    b0c = (gain_q > mll_pkg::GAIN_ONE) ? mll_pkg::GAIN_ONE : gain_q;
    a1c = pole_q;
    if (pole_q > mll_pkg::POLE_ONE)  a1c = mll_pkg::POLE_ONE;
    if (pole_q < mll_pkg::POLE_MONE) a1c = mll_pkg::POLE_MONE;
    kc  = (res_q > mll_pkg::RES_MAX) ? mll_pkg::RES_MAX : res_q;
    b0s = CW'(b0c);
    a1s = CW'(a1c);
    ks  = CW'(kc);
  end

  assign s0w = W'(st_q[0]);
  assign s1w = W'(st_q[1]);
  assign s2w = W'(st_q[2]);
  assign s3w = W'(st_q[3]);
  assign s_sel = W'(st_q[cmd_i.idx]);

  // shared coefficient multiplier, round half up
  always_comb begin
    mul_a = '0;
    mul_c = '0;
    case (cmd_i.op)
      mll_pkg::OP_B2:  begin mul_a = W'(b0s);    mul_c = b0s; end
      mll_pkg::OP_B4:  begin mul_a = W'(b2_q); mul_c = b2_q; end
      mll_pkg::OP_O1:  begin mul_a = s0w;        mul_c = b0s; end
      mll_pkg::OP_O2:  begin mul_a = s1w + t_q;  mul_c = b0s; end
      mll_pkg::OP_O3:  begin mul_a = s2w + t_q;  mul_c = b0s; end
      mll_pkg::OP_NUM: begin mul_a = x_q;        mul_c = b4_q; end
      mll_pkg::OP_DEN: begin mul_a = W'(ks);     mul_c = b4_q; end
      mll_pkg::OP_U:   begin mul_a = outs_q;     mul_c = ks; end
      mll_pkg::OP_BP:  begin mul_a = f_q;        mul_c = b0s; end
      mll_pkg::OP_N:   begin mul_a = f_q;        mul_c = a1s; end
      mll_pkg::OP_N4:  begin mul_a = outs_q;     mul_c = a1s; end
      default: ;
    endcase
    prod   = PW'(mul_a) * PW'(mul_c);
    prod_r = (prod + HALF) >>> FR;
    mul_r  = prod_r[W-1:0];
  end

  always_comb begin
    nv    = bp_q - mul_r;
    zap_v = (nv[W-1:StateBits-1] == '0 || nv[W-1:StateBits-1] == '1)
            ? nv[StateBits-1:0] : '0;
    mag   = num_q[W-1] ? -num_q : num_q;
    cand  = {rem_q, qr_q[DivBits-1]};
    quo   = qr_q[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) st_q[i] <= '0;
    end else begin
      case (cmd_i.op)
        mll_pkg::OP_LOAD: begin
          if (clear_state_i) for (int i = 0; i < 4; i++) st_q[i] <= '0;
        end
        mll_pkg::OP_N:  st_q[cmd_i.idx] <= zap_v;
        mll_pkg::OP_N4: st_q[3] <= zap_v;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mll_pkg::OP_LOAD:  x_q  <= W'(sample_in_i);
      mll_pkg::OP_B2:    b2_q <= mul_r[CW-1:0];
      mll_pkg::OP_B4:    b4_q <= mul_r[CW-1:0];
      mll_pkg::OP_O1:    t_q  <= mul_r;
      mll_pkg::OP_O2:    t_q  <= mul_r;
      mll_pkg::OP_O3:    t_q  <= s3w + mul_r;
      mll_pkg::OP_NUM:   num_q <= mul_r + t_q;
      mll_pkg::OP_DEN:   den_q <= DW'(ONE_W + mul_r);
      mll_pkg::OP_DINIT: begin
        neg_q <= num_q[W-1];
        rem_q <= '0;
        qr_q  <= DivBits'({unsigned'(mag), FR'(0)}) + DivBits'(den_q >> 1);
      end
      mll_pkg::OP_DSTEP: begin
        if (cand >= {1'b0, den_q}) begin
          rem_q <= DW'(cand - {1'b0, den_q});
          qr_q  <= {qr_q[DivBits-2:0], 1'b1};
        end else begin
          rem_q <= cand[DW-1:0];
          qr_q  <= {qr_q[DivBits-2:0], 1'b0};
        end
      end
      mll_pkg::OP_QUOT:  outs_q <= neg_q ? -quo : quo;
      mll_pkg::OP_U:     f_q  <= x_q - mul_r;
      mll_pkg::OP_BP:    bp_q <= mul_r;
      mll_pkg::OP_F:     f_q  <= bp_q + s_sel;
      mll_pkg::OP_OUT: begin
        if (outs_q[W-1:SampleBits-1] == '0 || outs_q[W-1:SampleBits-1] == '1)
          out_q <= outs_q[SampleBits-1:0];
        else
          out_q <= outs_q[W-1] ? {1'b1, {(SampleBits-1){1'b0}}}
                               : {1'b0, {(SampleBits-1){1'b1}}};
      end
      default: ;
    endcase
  end

  assign sample_out_o = out_q;

endmodule

/* rtl/core/mll_ctrl.sv */
module mll_ctrl #(
  parameter int DivSteps = mll_pkg::STATE_BITS + mll_pkg::HEADROOM + mll_pkg::COEF_FRAC + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mll_pkg::cmd_t cmd_o
);

  localparam int CNTW = $clog2(DivSteps);

  mll_pkg::state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [1:0]      idx_q, idx_d;
  logic            vld_q, vld_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mll_pkg::ST_IDLE:  if (in_valid_i) state_d = mll_pkg::ST_B2;
      mll_pkg::ST_B2:    state_d = mll_pkg::ST_B4;
      mll_pkg::ST_B4:    state_d = mll_pkg::ST_O1;
      mll_pkg::ST_O1:    state_d = mll_pkg::ST_O2;
      mll_pkg::ST_O2:    state_d = mll_pkg::ST_O3;
      mll_pkg::ST_O3:    state_d = mll_pkg::ST_NUM;
      mll_pkg::ST_NUM:   state_d = mll_pkg::ST_DEN;
      mll_pkg::ST_DEN:   state_d = mll_pkg::ST_DINIT;
      mll_pkg::ST_DINIT: state_d = mll_pkg::ST_DIV;
      mll_pkg::ST_DIV:   if (cnt_q == CNTW'(DivSteps - 1)) state_d = mll_pkg::ST_QUOT;
      mll_pkg::ST_QUOT:  state_d = mll_pkg::ST_U;
      mll_pkg::ST_U:     state_d = mll_pkg::ST_BP;
      mll_pkg::ST_BP:    state_d = mll_pkg::ST_F;
      mll_pkg::ST_F:     state_d = mll_pkg::ST_N;
      mll_pkg::ST_N:     state_d = (idx_q == 2'd2) ? mll_pkg::ST_BP4 : mll_pkg::ST_BP;
      mll_pkg::ST_BP4:   state_d = mll_pkg::ST_N4;
      mll_pkg::ST_N4:    state_d = mll_pkg::ST_OUT;
      mll_pkg::ST_OUT:   if (!vld_q || out_ready_i) state_d = mll_pkg::ST_IDLE;
      default:           state_d = mll_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = mll_pkg::OP_NONE;
    cmd_o.idx  = idx_q;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    vld_d      = vld_q && !out_ready_i;
    case (state_q)
      mll_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = mll_pkg::OP_LOAD;
      end
      mll_pkg::ST_B2:    cmd_o.op = mll_pkg::OP_B2;
      mll_pkg::ST_B4:    cmd_o.op = mll_pkg::OP_B4;
      mll_pkg::ST_O1:    cmd_o.op = mll_pkg::OP_O1;
      mll_pkg::ST_O2:    cmd_o.op = mll_pkg::OP_O2;
      mll_pkg::ST_O3:    cmd_o.op = mll_pkg::OP_O3;
      mll_pkg::ST_NUM:   cmd_o.op = mll_pkg::OP_NUM;
      mll_pkg::ST_DEN:   cmd_o.op = mll_pkg::OP_DEN;
      mll_pkg::ST_DINIT: begin
        cmd_o.op = mll_pkg::OP_DINIT;
        cnt_d    = '0;
      end
      mll_pkg::ST_DIV: begin
        cmd_o.op = mll_pkg::OP_DSTEP;
        cnt_d    = cnt_q + 1'b1;
      end
      mll_pkg::ST_QUOT:  cmd_o.op = mll_pkg::OP_QUOT;
      mll_pkg::ST_U: begin
        cmd_o.op = mll_pkg::OP_U;
        idx_d    = '0;
      end
      mll_pkg::ST_BP:    cmd_o.op = mll_pkg::OP_BP;
      mll_pkg::ST_F:     cmd_o.op = mll_pkg::OP_F;
      mll_pkg::ST_N: begin
        cmd_o.op = mll_pkg::OP_N;
        idx_d    = idx_q + 1'b1;
      end
      mll_pkg::ST_BP4:   cmd_o.op = mll_pkg::OP_BP;
      mll_pkg::ST_N4:    cmd_o.op = mll_pkg::OP_N4;
      mll_pkg::ST_OUT: begin
        if (!vld_q || out_ready_i) begin
          cmd_o.op = mll_pkg::OP_OUT;
          vld_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mll_pkg::ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      vld_q   <= vld_d;
    end
  end

  assign out_valid_o = vld_q;

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == mll_pkg::ST_B2))
    else $error("accepted item did not start the sequence");

  a_div_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mll_pkg::ST_DIV) |-> (cnt_q <= CNTW'(DivSteps - 1)))
    else $error("divider step count out of range");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == mll_pkg::OP_OUT) |-> (!vld_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_stage_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mll_pkg::ST_N) |-> (idx_q != 2'd3))
    else $error("stage index out of range");

endmodule

/* rtl/core/moog_ladder_lowpass_filter.sv */
// Four-stage ladder lowpass with the delay-free feedback loop solved in closed
// form, one Q1.23 sample per transaction. Software must write b0 (stage_gain,
// index 0), a1 (stage_pole, index 1) and k (resonance_gain, index 2, clipped to
// 4.0) only while the block is idle; the block itself does not enforce this. A
// transaction with clear_state set zeroes the four stage states before filtering
// that sample; a stage state that overflows is dropped to zero and the output
// saturates. The block accepts no new sample until the previous one has run
// through the whole sequence: the work runs on one shared rounding coefficient
// multiplier, and the normalizing division is a restoring divider that resolves
// one quotient bit per cycle over max(SampleBits, StateBits) + 33 steps. A
// finished result waits in the output register while the next sample is
// accepted.
module moog_ladder_lowpass_filter #(
  parameter int SampleBits = mll_pkg::SAMPLE_BITS,
  parameter int StateBits  = mll_pkg::STATE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SampleBits-1:0]      sample_in_i,
  input  logic                              clear_state_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SampleBits-1:0]      sample_out_o,
  input  logic                              cfg_we_i,
  input  logic [mll_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [mll_pkg::CFG_BITS-1:0]      cfg_data_i
);

  // working width: widest of sample and state, plus headroom for the loop gain
  localparam int WorkBits = ((SampleBits > StateBits) ? SampleBits : StateBits)
                            + mll_pkg::HEADROOM;
  localparam int DivBits  = WorkBits + mll_pkg::COEF_FRAC + 1;

  mll_pkg::cmd_t cmd;

  // sequence the multiply, divide and stage update steps
  mll_ctrl #(
    .DivSteps (DivBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // hold coefficients, stage states and the shared arithmetic
  mll_dp #(
    .SampleBits (SampleBits),
    .StateBits  (StateBits),
    .WorkBits   (WorkBits),
    .DivBits    (DivBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_in_i   (sample_in_i),
    .clear_state_i (clear_state_i),
    .sample_out_o  (sample_out_o)
  );

endmodule
